/* hw/rtl/hrlc_pkg.sv */
package hrlc_pkg;

    // Method codes reported in the result word
    localparam logic [2:0] METHOD_GET    = 3'd0;
    localparam logic [2:0] METHOD_POST   = 3'd1;
    localparam logic [2:0] METHOD_PUT    = 3'd2;
    localparam logic [2:0] METHOD_DELETE = 3'd3;
    localparam logic [2:0] METHOD_HEAD   = 3'd4;
    localparam logic [2:0] METHOD_NONE   = 3'd7;

    // Configuration register indexes
    localparam logic REG_URI_MAX     = 1'b0;
    localparam logic REG_VERSION_MAX = 1'b1;

    // Register reset values
    localparam logic [11:0] URI_MAX_RESET     = 12'd1023;
    localparam logic [5:0]  VERSION_MAX_RESET = 6'd15;

    // Field widths
    localparam int URI_LEN_W = 12;
    localparam int VER_LEN_W = 6;

    // Characters of interest
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_N       = 8'h6E;

    // Configuration values as seen by the parser
    typedef struct packed {
        logic [URI_LEN_W-1:0] uri_max;
        logic [VER_LEN_W-1:0] version_max;
    } cfg_t;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic                 escaped_terminator;
        logic [VER_LEN_W-1:0] version_length;
        logic [URI_LEN_W-1:0] uri_length;
        logic [2:0]           method_code;
        logic                 verdict;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

    // Match the collected method text against the known methods
    function automatic logic [2:0] method_lookup(input logic overflow,
                                                 input logic [2:0] count,
                                                 input logic [47:0] text);
        logic [2:0] code;
        code = METHOD_NONE;
        if (!overflow) begin
            if (count == 3'd3 && text == 48'h000000474554)
                code = METHOD_GET;
            else if (count == 3'd4 && text == 48'h0000504F5354)
                code = METHOD_POST;
            else if (count == 3'd3 && text == 48'h000000505554)
                code = METHOD_PUT;
            else if (count == 3'd6 && text == 48'h44454C455445)
                code = METHOD_DELETE;
            else if (count == 3'd4 && text == 48'h000048454144)
                code = METHOD_HEAD;
        end
        return code;
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
    endfunction

    // Letters, digits and the allowed punctuation of a URI
    function automatic logic uri_char_ok(input logic [7:0] b);
        logic ok;
        ok = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
             (b >= 8'h61 && b <= 8'h7A);
        unique case (b)
            8'h2E, 8'h2F, 8'h2D, 8'h20, 8'h5F, 8'h7E, 8'h21, 8'h24, 8'h26,
            8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D, 8'h3A,
            8'h40: ok = 1'b1;
            default: ;
        endcase
        return ok;
    endfunction

    // Expected byte at each place of the "HTTP/" prefix
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Expected byte at each place of the literal backslash-r-backslash-n text
    function automatic logic [7:0] escape_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0: c = CH_BSLASH;
            2'd1: c = CH_R;
            2'd2: c = CH_BSLASH;
            2'd3: c = CH_N;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/hrlc_cfg.sv */
module hrlc_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output hrlc_pkg::cfg_t      cfg
);

    logic [hrlc_pkg::URI_LEN_W-1:0] uri_max_reg;
    logic [hrlc_pkg::VER_LEN_W-1:0] version_max_reg;
    logic                           wr_en;
    logic                           reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Write registers on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uri_max_reg     <= hrlc_pkg::URI_MAX_RESET;
            version_max_reg <= hrlc_pkg::VERSION_MAX_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                hrlc_pkg::REG_URI_MAX:
                    uri_max_reg <= pwdata[hrlc_pkg::URI_LEN_W-1:0];
                hrlc_pkg::REG_VERSION_MAX:
                    version_max_reg <= pwdata[hrlc_pkg::VER_LEN_W-1:0];
            endcase
        end
    end

    // Read back, zero extended
    always_comb begin
        unique case (reg_idx)
            hrlc_pkg::REG_URI_MAX:
                prdata = {{(32-hrlc_pkg::URI_LEN_W){1'b0}}, uri_max_reg};
            hrlc_pkg::REG_VERSION_MAX:
                prdata = {{(32-hrlc_pkg::VER_LEN_W){1'b0}}, version_max_reg};
        endcase
    end

    assign cfg.uri_max     = uri_max_reg;
    assign cfg.version_max = version_max_reg;

endmodule

/* hw/rtl/hrlc_parse.sv */
module hrlc_parse (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                last,
    input  hrlc_pkg::cfg_t      cfg,
    output logic                res_valid,
    output hrlc_pkg::result_t   res
);

    typedef enum logic [1:0] {
        PH_METHOD,
        PH_URI,
        PH_VERSION,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [47:0] method_text_reg, method_text_next;
    logic [2:0]  method_count_reg, method_count_next;
    logic        method_overflow_reg, method_overflow_next;
    logic [2:0]  method_code_reg, method_code_next;
    logic        method_bad_reg, method_bad_next;
    logic [12:0] uri_count_reg, uri_count_next;
    logic        uri_error_reg, uri_error_next;
    logic [1:0]  hex_pending_reg, hex_pending_next;
    logic [6:0]  version_count_reg, version_count_next;
    logic [2:0]  prefix_match_reg, prefix_match_next;
    logic        prefix_fail_reg, prefix_fail_next;
    logic        carriage_seen_reg, carriage_seen_next;
    logic [1:0]  escape_match_reg, escape_match_next;
    logic        escape_found_reg, escape_found_next;
    logic [6:0]  escape_vcount_reg, escape_vcount_next;
    logic        escape_prefix_ok_reg, escape_prefix_ok_next;

    logic        lf_hit;
    logic [6:0]  lf_vlen;
    logic        lf_good;
    logic        esc_good;
    logic [2:0]  lookup_code;

    assign lookup_code = hrlc_pkg::method_lookup(method_overflow_reg, method_count_reg,
                                                 method_text_reg);

    // Per-byte state update
    always_comb begin
        phase_next            = phase_reg;
        method_text_next      = method_text_reg;
        method_count_next     = method_count_reg;
        method_overflow_next  = method_overflow_reg;
        method_code_next      = method_code_reg;
        method_bad_next       = method_bad_reg;
        uri_count_next        = uri_count_reg;
        uri_error_next        = uri_error_reg;
        hex_pending_next      = hex_pending_reg;
        version_count_next    = version_count_reg;
        prefix_match_next     = prefix_match_reg;
        prefix_fail_next      = prefix_fail_reg;
        carriage_seen_next    = carriage_seen_reg;
        escape_match_next     = escape_match_reg;
        escape_found_next     = escape_found_reg;
        escape_vcount_next    = escape_vcount_reg;
        escape_prefix_ok_next = escape_prefix_ok_reg;
        lf_hit                = 1'b0;

        unique case (phase_reg)
            PH_METHOD: begin
                if (data_byte == hrlc_pkg::CH_SPACE) begin
                    method_code_next = lookup_code;
                    method_bad_next  = (lookup_code == hrlc_pkg::METHOD_NONE);
                    phase_next       = PH_URI;
                end else if (method_count_reg < 3'd6) begin
                    method_text_next  = {method_text_reg[39:0], data_byte};
                    method_count_next = method_count_reg + 3'd1;
                end else begin
                    method_overflow_next = 1'b1;
                end
            end
            PH_URI: begin
                if (data_byte == hrlc_pkg::CH_SPACE) begin
                    if (hex_pending_reg != 2'd0 ||
                        uri_count_reg > {1'b0, cfg.uri_max})
                        uri_error_next = 1'b1;
                    phase_next = PH_VERSION;
                end else begin
                    if (uri_count_reg != 13'h1FFF)
                        uri_count_next = uri_count_reg + 13'd1;
                    if (hex_pending_reg != 2'd0) begin
                        if (hrlc_pkg::is_hex(data_byte))
                            hex_pending_next = hex_pending_reg - 2'd1;
                        else
                            uri_error_next = 1'b1;
                    end else if (data_byte == hrlc_pkg::CH_PERCENT) begin
                        hex_pending_next = 2'd2;
                    end else if (!hrlc_pkg::uri_char_ok(data_byte)) begin
                        uri_error_next = 1'b1;
                    end
                end
            end
            PH_VERSION: begin
                if (carriage_seen_reg && data_byte == hrlc_pkg::CH_LF) begin
                    lf_hit     = 1'b1;
                    phase_next = PH_DONE;
                end else begin
                    // Track the HTTP/ prefix
                    if (!prefix_fail_reg && prefix_match_reg < 3'd5) begin
                        if (hrlc_pkg::prefix_char(prefix_match_reg) == data_byte)
                            prefix_match_next = prefix_match_reg + 3'd1;
                        else
                            prefix_fail_next = 1'b1;
                    end
                    // Track the literal terminator text
                    if (!escape_found_reg) begin
                        if (hrlc_pkg::escape_char(escape_match_reg) == data_byte) begin
                            if (escape_match_reg == 2'd3) begin
                                escape_found_next     = 1'b1;
                                escape_vcount_next    = version_count_reg - 7'd3;
                                escape_prefix_ok_next = (prefix_match_next == 3'd5);
                                escape_match_next     = 2'd0;
                            end else begin
                                escape_match_next = escape_match_reg + 2'd1;
                            end
                        end else if (escape_match_reg == 2'd3 &&
                                     data_byte == hrlc_pkg::CH_R) begin
                            escape_match_next = 2'd2;
                        end else begin
                            escape_match_next = (data_byte == hrlc_pkg::CH_BSLASH) ?
                                                2'd1 : 2'd0;
                        end
                    end
                    carriage_seen_next = (data_byte == hrlc_pkg::CH_CR);
                    if (version_count_reg != 7'd127)
                        version_count_next = version_count_reg + 7'd1;
                end
            end
            PH_DONE: ;
        endcase
    end

    // Verdicts for the two ways a line can end
    assign lf_vlen  = version_count_reg - 7'd1;
    assign lf_good  = !method_bad_reg && !uri_error_reg &&
                      (lf_vlen <= {1'b0, cfg.version_max}) && (prefix_match_reg == 3'd5);
    assign esc_good = (phase_next == PH_VERSION) && escape_found_next &&
                      !method_bad_reg && !uri_error_reg &&
                      (escape_vcount_next <= {1'b0, cfg.version_max}) &&
                      escape_prefix_ok_next;

    // Build the result word
    always_comb begin
        res       = '0;
        res_valid = 1'b0;
        if (lf_hit) begin
            res_valid = 1'b1;
            if (lf_good) begin
                res.method_code    = method_code_reg;
                res.uri_length     = uri_count_reg[hrlc_pkg::URI_LEN_W-1:0];
                res.version_length = lf_vlen[hrlc_pkg::VER_LEN_W-1:0];
            end else begin
                res.verdict = 1'b1;
            end
        end else if (last && phase_reg != PH_DONE) begin
            res_valid = 1'b1;
            if (esc_good) begin
                res.method_code        = method_code_reg;
                res.uri_length         = uri_count_reg[hrlc_pkg::URI_LEN_W-1:0];
                res.version_length     = escape_vcount_next[hrlc_pkg::VER_LEN_W-1:0];
                res.escaped_terminator = 1'b1;
            end else begin
                res.verdict = 1'b1;
            end
        end
    end

    // Hold request state; clear it after the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last)) begin
            phase_reg            <= PH_METHOD;
            method_text_reg      <= '0;
            method_count_reg     <= '0;
            method_overflow_reg  <= 1'b0;
            method_code_reg      <= hrlc_pkg::METHOD_GET;
            method_bad_reg       <= 1'b0;
            uri_count_reg        <= '0;
            uri_error_reg        <= 1'b0;
            hex_pending_reg      <= '0;
            version_count_reg    <= '0;
            prefix_match_reg     <= '0;
            prefix_fail_reg      <= 1'b0;
            carriage_seen_reg    <= 1'b0;
            escape_match_reg     <= '0;
            escape_found_reg     <= 1'b0;
            escape_vcount_reg    <= '0;
            escape_prefix_ok_reg <= 1'b0;
        end else if (step) begin
            phase_reg            <= phase_next;
            method_text_reg      <= method_text_next;
            method_count_reg     <= method_count_next;
            method_overflow_reg  <= method_overflow_next;
            method_code_reg      <= method_code_next;
            method_bad_reg       <= method_bad_next;
            uri_count_reg        <= uri_count_next;
            uri_error_reg        <= uri_error_next;
            hex_pending_reg      <= hex_pending_next;
            version_count_reg    <= version_count_next;
            prefix_match_reg     <= prefix_match_next;
            prefix_fail_reg      <= prefix_fail_next;
            carriage_seen_reg    <= carriage_seen_next;
            escape_match_reg     <= escape_match_next;
            escape_found_reg     <= escape_found_next;
            escape_vcount_reg    <= escape_vcount_next;
            escape_prefix_ok_reg <= escape_prefix_ok_next;
        end
    end

endmodule

/* hw/rtl/http_request_line_checker_core.sv */
// HTTP request line checker. Request bytes enter on the s_ stream, one byte per
// word, with s_tlast on the final byte of a request. The method, URI and version
// of the request line are checked and one result word leaves on the m_ stream,
// either on the LF of the first CR LF after the URI or on the final byte. The
// block takes one byte every cycle unless the result register is stalled; a byte
// waits in the input register, and when it advances the parser updates its
// per-byte state while the result register loads the result shown on m_. A
// result held by m_tready low stalls the input register. Limits on the URI and
// version lengths sit in two APB registers at addresses 0x0 and 0x4; write them
// only while no request is in flight.
module http_request_line_checker_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Request bytes
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,   // end_of_request
    // Results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] verdict, [3:1] method_code, [15:4] uri_length,
    // [21:16] version_length, [22] escaped_terminator, [23] zero
    output logic [hrlc_pkg::M_DATA_W-1:0] m_tdata,
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    hrlc_pkg::cfg_t    cfg;
    hrlc_pkg::result_t res;
    hrlc_pkg::result_t out_data_reg;
    logic              res_valid;
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    logic              advance;

    hrlc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Move the held byte through the parser when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    hrlc_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last      (in_last_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(hrlc_pkg::M_DATA_W-hrlc_pkg::RESULT_W){1'b0}}, out_data_reg};

endmodule

/* dv/http_request_line_checker_core_tb.sv */
`timescale 1ns / 1ps

module http_request_line_checker_core_tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES = 160;

    // Parser position within the request line
    typedef enum logic [1:0] {
        LINE_METHOD,
        LINE_URI,
        LINE_VERSION,
        LINE_DONE
    } line_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } req_word_t;

    typedef logic [7:0] byte_list_t[$];

    localparam logic [39:0] PREFIX_TEXT = "HTTP/";
    localparam logic [31:0] ESC_TEXT    = "\\r\\n";

    logic aclk;
    logic aresetn = 1'b0;

    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata  = '0;
    logic                          s_tlast  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [hrlc_pkg::M_DATA_W-1:0] m_tdata;
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [2:0]                    paddr    = '0;
    logic [31:0]                   pwdata   = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    http_request_line_checker_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Stimulus and scoreboard storage
    req_word_t         byte_feed[$];
    hrlc_pkg::result_t verdict_q[$];
    req_word_t         drive_word;
    int                send_idle_pct = 36;
    int                recv_idle_pct = 62;
    int                mismatches = 0;
    int                cycle_count = 0;
    int                fed_bytes = 0;

    string method_names[5] = '{"GET", "POST", "PUT", "DELETE", "HEAD"};
    string uri_chars =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789./-_~!$&'()*+,;=:@";
    string hex_chars = "0123456789abcdefABCDEF";

    // Predictor copy of the limits and the per-request parse state
    logic [11:0] uri_limit = hrlc_pkg::URI_MAX_RESET;
    logic [5:0]  ver_limit = hrlc_pkg::VERSION_MAX_RESET;
    line_phase_t line_ph;
    logic [47:0] meth_text;
    logic [2:0]  meth_count;
    logic        meth_over;
    logic        meth_bad;
    logic [12:0] uri_count;
    logic        uri_bad;
    logic [1:0]  hex_left;
    logic [6:0]  ver_count;
    logic [2:0]  pfx_match;
    logic        pfx_fail;
    logic        cr_seen;
    logic [1:0]  esc_match;
    logic        esc_found;
    logic [6:0]  esc_ver_count;
    logic        esc_pfx_ok;
    logic        line_reported;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [2:0] method_code_of();
        if (meth_over)
            return hrlc_pkg::METHOD_NONE;
        if (meth_count == 3'd3 && meth_text == {24'd0, "GET"})
            return hrlc_pkg::METHOD_GET;
        if (meth_count == 3'd4 && meth_text == {16'd0, "POST"})
            return hrlc_pkg::METHOD_POST;
        if (meth_count == 3'd3 && meth_text == {24'd0, "PUT"})
            return hrlc_pkg::METHOD_PUT;
        if (meth_count == 3'd6 && meth_text == "DELETE")
            return hrlc_pkg::METHOD_DELETE;
        if (meth_count == 3'd4 && meth_text == {16'd0, "HEAD"})
            return hrlc_pkg::METHOD_HEAD;
        return hrlc_pkg::METHOD_NONE;
    endfunction

    function automatic logic hex_digit(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic logic uri_byte_ok(input logic [7:0] b);
        if ((b >= "0" && b <= "9") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z"))
            return 1'b1;
        case (b)
            ".", "/", "-", " ", "_", "~", "!", "$", "&", "'", "(", ")", "*", "+", ",",
            ";", "=", ":", "@": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic hrlc_pkg::result_t line_result(input logic reached,
                                                      input logic [6:0] vlen,
                                                      input logic pfx_ok,
                                                      input logic escaped);
        hrlc_pkg::result_t r;
        logic [2:0] code;
        logic good;
        code = method_code_of();
        good = reached && !meth_bad && code != hrlc_pkg::METHOD_NONE && !uri_bad &&
               vlen <= {1'b0, ver_limit} && pfx_ok;
        r = '0;
        r.verdict = !good;
        if (good) begin
            r.method_code        = code;
            r.uri_length         = uri_count[11:0];
            r.version_length     = vlen[5:0];
            r.escaped_terminator = escaped;
        end
        return r;
    endfunction

    task automatic clear_line();
        line_ph       = LINE_METHOD;
        meth_text     = '0;
        meth_count    = '0;
        meth_over     = 1'b0;
        meth_bad      = 1'b0;
        uri_count     = '0;
        uri_bad       = 1'b0;
        hex_left      = '0;
        ver_count     = '0;
        pfx_match     = '0;
        pfx_fail      = 1'b0;
        cr_seen       = 1'b0;
        esc_match     = '0;
        esc_found     = 1'b0;
        esc_ver_count = '0;
        esc_pfx_ok    = 1'b0;
        line_reported = 1'b0;
    endtask

    // Advance the request-line parse by one byte and queue any verdict it causes
    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [6:0] old;
        case (line_ph)
            LINE_METHOD: begin
                if (b == hrlc_pkg::CH_SPACE) begin
                    if (method_code_of() == hrlc_pkg::METHOD_NONE)
                        meth_bad = 1'b1;
                    line_ph = LINE_URI;
                end else if (meth_count < 3'd6) begin
                    meth_text  = {meth_text[39:0], b};
                    meth_count = meth_count + 3'd1;
                end else begin
                    meth_over = 1'b1;
                end
            end
            LINE_URI: begin
                if (b == hrlc_pkg::CH_SPACE) begin
                    if (hex_left != 0 || uri_count > {1'b0, uri_limit})
                        uri_bad = 1'b1;
                    line_ph = LINE_VERSION;
                end else begin
                    if (uri_count != 13'h1FFF)
                        uri_count = uri_count + 13'd1;
                    if (hex_left != 0) begin
                        if (hex_digit(b))
                            hex_left = hex_left - 2'd1;
                        else
                            uri_bad = 1'b1;
                    end else if (b == hrlc_pkg::CH_PERCENT) begin
                        hex_left = 2'd2;
                    end else if (!uri_byte_ok(b)) begin
                        uri_bad = 1'b1;
                    end
                end
            end
            LINE_VERSION: begin
                old = ver_count;
                if (cr_seen && b == hrlc_pkg::CH_LF) begin
                    verdict_q.push_back(line_result(1'b1, old - 7'd1, pfx_match == 3'd5,
                                                    1'b0));
                    line_ph = LINE_DONE;
                    line_reported = 1'b1;
                end else begin
                    // Track the HTTP/ prefix
                    if (!pfx_fail && pfx_match < 3'd5) begin
                        if (PREFIX_TEXT[8*(4-int'(pfx_match)) +: 8] == b)
                            pfx_match = pfx_match + 3'd1;
                        else
                            pfx_fail = 1'b1;
                    end
                    // Hunt for the literal escaped terminator
                    if (!esc_found) begin
                        if (ESC_TEXT[8*(3-int'(esc_match)) +: 8] == b) begin
                            if (esc_match == 2'd3) begin
                                esc_found     = 1'b1;
                                esc_ver_count = old - 7'd3;
                                esc_pfx_ok    = (pfx_match == 3'd5);
                                esc_match     = 2'd0;
                            end else begin
                                esc_match = esc_match + 2'd1;
                            end
                        end else if (esc_match == 2'd3 && b == hrlc_pkg::CH_R) begin
                            esc_match = 2'd2;
                        end else begin
                            esc_match = (b == hrlc_pkg::CH_BSLASH) ? 2'd1 : 2'd0;
                        end
                    end
                    cr_seen = (b == hrlc_pkg::CH_CR);
                    if (ver_count != 7'd127)
                        ver_count = ver_count + 7'd1;
                end
            end
            default: ;
        endcase

        if (last) begin
            if (!line_reported) begin
                if (line_ph == LINE_VERSION && esc_found)
                    verdict_q.push_back(line_result(1'b1, esc_ver_count, esc_pfx_ok, 1'b1));
                else
                    verdict_q.push_back(line_result(1'b0, 7'd0, 1'b0, 1'b0));
            end
            clear_line();
        end
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s", $time, what);
    endtask

    task automatic check_verdict(input hrlc_pkg::result_t got);
        hrlc_pkg::result_t want;
        if (verdict_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected result %h", got));
        end else begin
            want = verdict_q.pop_front();
            if (got.verdict !== want.verdict || got.method_code !== want.method_code ||
                got.uri_length !== want.uri_length ||
                got.version_length !== want.version_length ||
                got.escaped_terminator !== want.escaped_terminator)
                flag_mismatch($sformatf({"exp bad=%0d meth=%0d uri=%0d ver=%0d esc=%0d ",
                                         "got bad=%0d meth=%0d uri=%0d ver=%0d esc=%0d"},
                    want.verdict, want.method_code, want.uri_length, want.version_length,
                    want.escaped_terminator, got.verdict, got.method_code, got.uri_length,
                    got.version_length, got.escaped_terminator));
        end
    endtask

    initial clear_line();

    // Drive request bytes from the feed queue with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drive_word = byte_feed.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= drive_word.data;
                s_tlast  <= drive_word.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Stall the result side at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Predict on accepted bytes, then check accepted result words
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_verdict(hrlc_pkg::result_t'(m_tdata[hrlc_pkg::RESULT_W-1:0]));
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic apb_write(input logic idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Upper bits carry noise; the registers keep only their own width
    task automatic set_limits(input logic [11:0] uri_max, input logic [5:0] ver_max);
        apb_write(hrlc_pkg::REG_URI_MAX, {20'($urandom), uri_max});
        uri_limit = uri_max;
        apb_write(hrlc_pkg::REG_VERSION_MAX, {26'($urandom), ver_max});
        ver_limit = ver_max;
    endtask

    task automatic drain();
        while (byte_feed.size() != 0 || s_tvalid || verdict_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic add_text(ref byte_list_t req, input string s);
        for (int i = 0; i < s.len(); i++)
            req.push_back(s[i]);
    endtask

    task automatic send_request(input byte_list_t req);
        req_word_t w;
        for (int i = 0; i < req.size(); i++) begin
            w.data = req[i];
            w.last = (i == req.size() - 1);
            byte_feed.push_back(w);
        end
        fed_bytes += req.size();
    endtask

    task automatic send_line(input string s, input bit crlf);
        byte_list_t req;
        add_text(req, s);
        if (crlf) begin
            req.push_back(hrlc_pkg::CH_CR);
            req.push_back(hrlc_pkg::CH_LF);
        end
        send_request(req);
    endtask

    task automatic long_request(input int ulen, input int vlen);
        byte_list_t req;
        add_text(req, "GET ");
        repeat (ulen) req.push_back("a");
        add_text(req, " HTTP/");
        repeat (vlen - 5) req.push_back("1");
        req.push_back(hrlc_pkg::CH_CR);
        req.push_back(hrlc_pkg::CH_LF);
        send_request(req);
    endtask

    // Build one request: mostly well-formed lines with random content, some noise
    task automatic gen_request(input int uri_hi, input int ver_hi);
        byte_list_t req;
        string meth;
        int pick, len, start;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 10) begin
            len = $urandom_range(1, 24);
            repeat (len) req.push_back(8'($urandom));
            send_request(req);
            return;
        end

        // Method
        meth = method_names[$urandom_range(4)];
        pick = $urandom_range(99);
        if (pick < 80) begin
            add_text(req, meth);
        end else if (pick < 85) begin
            add_text(req, meth);
            req[$urandom_range(req.size() - 1)] = 8'($urandom);
        end else if (pick < 90) begin
            add_text(req, {meth, "S"});
        end else if (pick < 95) begin
            len = $urandom_range(0, 9);
            repeat (len) req.push_back(8'($urandom_range(65, 90)));
        end else begin
            len = $urandom_range(0, meth.len() - 1);
            for (int i = 0; i < len; i++)
                req.push_back(meth[i]);
        end
        req.push_back(hrlc_pkg::CH_SPACE);

        // URI
        len = ($urandom_range(99) < 60) ? $urandom_range(0, 12) : $urandom_range(0, uri_hi);
        start = req.size();
        while (req.size() - start < len) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                req.push_back(hrlc_pkg::CH_PERCENT);
                req.push_back(hex_chars[$urandom_range(hex_chars.len() - 1)]);
                req.push_back(hex_chars[$urandom_range(hex_chars.len() - 1)]);
            end else if (pick < 10) begin
                req.push_back(hrlc_pkg::CH_PERCENT);
                req.push_back(uri_chars[$urandom_range(uri_chars.len() - 1)]);
            end else if (pick < 12) begin
                b = 8'($urandom);
                req.push_back((b == hrlc_pkg::CH_SPACE) ? 8'h7F : b);
            end else begin
                req.push_back(uri_chars[$urandom_range(uri_chars.len() - 1)]);
            end
        end
        if ($urandom_range(99) < 4)
            req.push_back(hrlc_pkg::CH_PERCENT);
        req.push_back(hrlc_pkg::CH_SPACE);

        // Version
        pick = $urandom_range(99);
        if (pick < 70) begin
            add_text(req, "HTTP/1.1");
        end else if (pick < 80) begin
            add_text(req, "HTTP/");
            len = $urandom_range(0, ver_hi);
            repeat (len)
                req.push_back(($urandom_range(3) == 0) ? 8'h2E : 8'($urandom_range(48, 57)));
        end else if (pick < 90) begin
            start = req.size();
            add_text(req, "HTTP/1.1");
            req[start + $urandom_range(4)] = 8'($urandom_range(33, 126));
        end else begin
            len = $urandom_range(0, ver_hi);
            repeat (len) req.push_back(8'($urandom_range(33, 126)));
        end

        // Terminator
        pick = $urandom_range(99);
        if (pick < 65) begin
            req.push_back(hrlc_pkg::CH_CR);
            req.push_back(hrlc_pkg::CH_LF);
        end else if (pick < 77) begin
            add_text(req, "\\r\\n");
        end else if (pick < 82) begin
            add_text(req, "\\r\\nX-A");
            req.push_back(hrlc_pkg::CH_CR);
            req.push_back(hrlc_pkg::CH_LF);
        end else if (pick < 87) begin
            add_text(req, "\\r\\r\\n");
        end else if (pick < 92) begin
            req.push_back(hrlc_pkg::CH_CR);
        end

        // Trailing header or body bytes
        if ($urandom_range(1) == 1) begin
            len = $urandom_range(1, 16);
            repeat (len) req.push_back(8'($urandom));
        end

        // Occasionally cut the request short
        if ($urandom_range(99) < 5)
            req = req[0:$urandom_range(0, req.size() - 1)];
        send_request(req);
    endtask

    task automatic run_phase(input logic [11:0] uri_max, input logic [5:0] ver_max,
                             input int send_pct, input int recv_pct, input bit with_long);
        int uri_hi;
        set_limits(uri_max, ver_max);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
        uri_hi = (int'(uri_max) + 3 > 40) ? 40 : int'(uri_max) + 3;
        if (with_long) begin
            long_request(100, 8);
            long_request(101, 8);
            long_request(3, 63);
            long_request(3, 64);
            long_request(3, 130);
        end
        fed_bytes = 0;
        while (fed_bytes < PHASE_BYTES)
            gen_request(uri_hi, int'(ver_max) + 3);
        drain();
    endtask

    initial begin
        byte_list_t one;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extreme bytes, escapes, both terminators, missing space
        one = '{8'hFF};
        send_request(one);
        one = '{8'h00};
        send_request(one);
        send_line("GET %4F HTTP/", 1'b1);
        send_line("DELETE ~ HTTP/1\\r\\n", 1'b0);
        send_line("HEAD /", 1'b0);
        drain();

        run_phase(12'd0,    6'd63, 36, 62, 1'b0);
        run_phase(12'd4095, 6'd0,  36, 62, 1'b0);
        run_phase(12'd8,    6'd9,  62, 36, 1'b0);
        run_phase(12'd100,  6'd63, 62, 36, 1'b1);
        run_phase(12'd20,   6'd12, 0,  0,  1'b0);
        run_phase(12'd1023, 6'd15, 0,  0,  1'b0);

        if (verdict_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/hrlc_pkg.sv
hw/rtl/hrlc_cfg.sv
hw/rtl/hrlc_parse.sv
hw/rtl/http_request_line_checker_core.sv
dv/http_request_line_checker_core_tb.sv
